// ----- rtl/dctl_pkg.sv -----
// Package: shared types, codes, constants and saturation helpers of the drive/clip/tone/level chain
`timescale 1ns / 1ps

package dctl_pkg;

   localparam int CHANNELS = 2;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 26;
   localparam int DRIVE_W  = 23;
   localparam int LEVEL_W  = 17;
   localparam int STATE_W  = 48;
   localparam int PROD_W   = 50;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 26;

   localparam logic [DRIVE_W-1:0]        DRIVE_RESET = 23'd65536;
   localparam logic signed [COEF_W-1:0]  B0_RESET    = 26'sd4194304;
   localparam logic [LEVEL_W-1:0]        LEVEL_RESET = 17'd65536;

   localparam logic signed [PROD_W-1:0] S24_MAX = 50'sd8388607;
   localparam logic signed [PROD_W-1:0] S24_MIN = -50'sd8388608;
   localparam logic signed [PROD_W-1:0] S48_MAX = 50'sd140737488355327;
   localparam logic signed [PROD_W-1:0] S48_MIN = -50'sd140737488355328;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DRIVE_GAIN = 3'd0,
      REG_TONE_B0    = 3'd1,
      REG_TONE_B1    = 3'd2,
      REG_TONE_B2    = 3'd3,
      REG_TONE_A1    = 3'd4,
      REG_TONE_A2    = 3'd5,
      REG_LEVEL_GAIN = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      MSEL_DRIVE,
      MSEL_B0,
      MSEL_B1,
      MSEL_B2,
      MSEL_A1,
      MSEL_A2,
      MSEL_LEVEL
   } mul_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLIP,
      OP_ACC,
      OP_Y,
      OP_S2W,
      OP_S1,
      OP_S2,
      OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLIP,
      ST_B0,
      ST_B1,
      ST_B2,
      ST_A1,
      ST_A2,
      ST_LVL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        mul_en;
      mul_sel_type mul_sel;
      op_type      op;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      if (v > S24_MAX) begin
         r = S24_MAX;
      end else if (v < S24_MIN) begin
         r = S24_MIN;
      end else begin
         r = v;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      if (v > S48_MAX) begin
         r = S48_MAX;
      end else if (v < S48_MIN) begin
         r = S48_MIN;
      end else begin
         r = v;
      end
      return r[STATE_W-1:0];
   endfunction

endpackage

// ----- rtl/dctl_req_if.sv -----
// Interface: input sample channel (valid/ready with channel tag and sample)
`timescale 1ns / 1ps

interface dctl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  channel_index;
   logic signed [dctl_pkg::SAMPLE_W-1:0]  sample_in;

   modport source (output valid, output channel_index, output sample_in, input ready);
   modport sink   (input valid, input channel_index, input sample_in, output ready);
endinterface

// ----- rtl/dctl_rsp_if.sv -----
// Interface: processed sample channel (valid/ready with channel tag and sample)
`timescale 1ns / 1ps

interface dctl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  channel_out;
   logic signed [dctl_pkg::SAMPLE_W-1:0]  sample_out;

   modport source (output valid, output channel_out, output sample_out, input ready);
   modport sink   (input valid, input channel_out, input sample_out, output ready);
endinterface

// ----- rtl/dctl_dp.sv -----
// Datapath: settings registers, shared multiplier, filter state and output word register
`timescale 1ns / 1ps

module dctl_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dctl_pkg::cmd_type                    cmd,
   output dctl_pkg::stat_type                   stat,
   input  logic                                 csr_wr_en,
   input  logic [dctl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dctl_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_channel_index,
   input  logic signed [dctl_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_channel_out,
   output logic signed [dctl_pkg::SAMPLE_W-1:0] rsp_sample_out
);

   // settings
   logic [dctl_pkg::DRIVE_W-1:0]        drive_ff;
   logic signed [dctl_pkg::COEF_W-1:0]  b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   logic [dctl_pkg::LEVEL_W-1:0]        level_ff;

   // per-channel filter state
   logic signed [dctl_pkg::STATE_W-1:0] s1_ff [dctl_pkg::CHANNELS];
   logic signed [dctl_pkg::STATE_W-1:0] s2_ff [dctl_pkg::CHANNELS];

   // working registers
   logic [dctl_pkg::CH_W-1:0]            ch_ff;
   logic                                 chan_ff;
   logic signed [dctl_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [dctl_pkg::SAMPLE_W-1:0] c_ff, y_ff;
   logic signed [dctl_pkg::STATE_W-1:0]  acc_ff;
   logic signed [dctl_pkg::PROD_W-1:0]   s1w_ff;
   logic signed [34:0]                   s2w_ff;

   logic                                 rsp_valid_ff;
   logic                                 rsp_chan_ff;
   logic signed [dctl_pkg::SAMPLE_W-1:0] rsp_sample_ff;

   logic signed [dctl_pkg::COEF_W-1:0]   op_a;
   logic signed [dctl_pkg::SAMPLE_W-1:0] op_b;
   logic signed [34:0]                   p35;

   always_comb begin
      case (cmd.mul_sel)
         dctl_pkg::MSEL_DRIVE: begin
            op_a = $signed({3'b000, drive_ff});
            op_b = req_sample_in;
         end
         dctl_pkg::MSEL_B0: begin
            op_a = b0_ff;
            op_b = c_ff;
         end
         dctl_pkg::MSEL_B1: begin
            op_a = b1_ff;
            op_b = c_ff;
         end
         dctl_pkg::MSEL_B2: begin
            op_a = b2_ff;
            op_b = c_ff;
         end
         dctl_pkg::MSEL_A1: begin
            op_a = a1_ff;
            op_b = y_ff;
         end
         dctl_pkg::MSEL_A2: begin
            op_a = a2_ff;
            op_b = y_ff;
         end
         dctl_pkg::MSEL_LEVEL: begin
            op_a = $signed({9'b0, level_ff});
            op_b = y_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = dctl_pkg::PROD_W'(op_a) * dctl_pkg::PROD_W'(op_b);
   assign p35     = prod_ff[dctl_pkg::PROD_W-1:15];

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= dctl_pkg::DRIVE_RESET;
         b0_ff    <= dctl_pkg::B0_RESET;
         b1_ff    <= '0;
         b2_ff    <= '0;
         a1_ff    <= '0;
         a2_ff    <= '0;
         level_ff <= dctl_pkg::LEVEL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dctl_pkg::REG_DRIVE_GAIN: drive_ff <= csr_wdata[dctl_pkg::DRIVE_W-1:0];
            dctl_pkg::REG_TONE_B0:    b0_ff    <= $signed(csr_wdata);
            dctl_pkg::REG_TONE_B1:    b1_ff    <= $signed(csr_wdata);
            dctl_pkg::REG_TONE_B2:    b2_ff    <= $signed(csr_wdata);
            dctl_pkg::REG_TONE_A1:    a1_ff    <= $signed(csr_wdata);
            dctl_pkg::REG_TONE_A2:    a2_ff    <= $signed(csr_wdata);
            dctl_pkg::REG_LEVEL_GAIN: level_ff <= csr_wdata[dctl_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dctl_pkg::CHANNELS; i++) begin
            s1_ff[i] <= '0;
            s2_ff[i] <= '0;
         end
      end else if (cmd.op == dctl_pkg::OP_S1) begin
         s1_ff[ch_ff] <= dctl_pkg::sat48(s1w_ff - dctl_pkg::PROD_W'(p35));
      end else if (cmd.op == dctl_pkg::OP_S2) begin
         s2_ff[ch_ff] <= dctl_pkg::sat48(dctl_pkg::PROD_W'(s2w_ff) - dctl_pkg::PROD_W'(p35));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      case (cmd.op)
         dctl_pkg::OP_LOAD: begin
            chan_ff <= req_channel_index;
            ch_ff   <= (dctl_pkg::CHANNELS > 1) ? dctl_pkg::CH_W'(req_channel_index) : '0;
         end
         dctl_pkg::OP_CLIP: c_ff <= dctl_pkg::sat24(prod_ff >>> 16);
         dctl_pkg::OP_ACC: begin
            acc_ff <= dctl_pkg::sat48(dctl_pkg::PROD_W'(p35) + dctl_pkg::PROD_W'(s1_ff[ch_ff]));
         end
         dctl_pkg::OP_Y: begin
            y_ff   <= dctl_pkg::sat24(dctl_pkg::PROD_W'(acc_ff >>> 7));
            s1w_ff <= dctl_pkg::PROD_W'(p35) + dctl_pkg::PROD_W'(s2_ff[ch_ff]);
         end
         dctl_pkg::OP_S2W: s2w_ff <= p35;
         default: ;
      endcase
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == dctl_pkg::OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == dctl_pkg::OP_OUT) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= dctl_pkg::sat24(prod_ff >>> 16);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_chan_ff;
   assign rsp_sample_out  = rsp_sample_ff;

endmodule

// ----- rtl/dctl_ctrl.sv -----
// Controller: sequences the shared multiplier and datapath steps for one word
`timescale 1ns / 1ps

module dctl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dctl_pkg::stat_type stat,
   output dctl_pkg::cmd_type  cmd
);

   dctl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dctl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.mul_en  = 1'b0;
      cmd.mul_sel = dctl_pkg::MSEL_DRIVE;
      cmd.op      = dctl_pkg::OP_NONE;
      case (state_ff)
         dctl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.mul_en = 1'b1;
               cmd.op     = dctl_pkg::OP_LOAD;
               state_in   = dctl_pkg::ST_CLIP;
            end
         end
         dctl_pkg::ST_CLIP: begin
            cmd.op   = dctl_pkg::OP_CLIP;
            state_in = dctl_pkg::ST_B0;
         end
         dctl_pkg::ST_B0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dctl_pkg::MSEL_B0;
            state_in    = dctl_pkg::ST_B1;
         end
         dctl_pkg::ST_B1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dctl_pkg::MSEL_B1;
            cmd.op      = dctl_pkg::OP_ACC;
            state_in    = dctl_pkg::ST_B2;
         end
         dctl_pkg::ST_B2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dctl_pkg::MSEL_B2;
            cmd.op      = dctl_pkg::OP_Y;
            state_in    = dctl_pkg::ST_A1;
         end
         dctl_pkg::ST_A1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dctl_pkg::MSEL_A1;
            cmd.op      = dctl_pkg::OP_S2W;
            state_in    = dctl_pkg::ST_A2;
         end
         dctl_pkg::ST_A2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dctl_pkg::MSEL_A2;
            cmd.op      = dctl_pkg::OP_S1;
            state_in    = dctl_pkg::ST_LVL;
         end
         dctl_pkg::ST_LVL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = dctl_pkg::MSEL_LEVEL;
            cmd.op      = dctl_pkg::OP_S2;
            state_in    = dctl_pkg::ST_OUT;
         end
         dctl_pkg::ST_OUT: begin
            if (stat.out_free) begin
               cmd.op   = dctl_pkg::OP_OUT;
               state_in = dctl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dctl_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/drive_clip_tone_level_chain_core.sv -----
// Top level: drive gain, hard clip, per-channel biquad tone filter and output level chain
// An accepted word steps from ST_CLIP to ST_LVL and waits in ST_OUT while rsp stalls;
// rsp valid rises as it leaves ST_OUT; a new word is taken only in ST_IDLE. One shared
// 26x24 multiplier does a word's seven products in turn; its registered result feeds
// the next step. The output word register lets a new word in while a result waits.
// Reset (synchronous, active high): filter state cleared, settings to defaults.
`timescale 1ns / 1ps

module drive_clip_tone_level_chain_core (
   input  logic                              clock,
   input  logic                              reset,
   dctl_req_if.sink                          req_chan,
   dctl_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [dctl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dctl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   dctl_pkg::cmd_type  cmd;
   dctl_pkg::stat_type stat;

   dctl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dctl_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_channel_index (req_chan.channel_index),
      .req_sample_in     (req_chan.sample_in),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_channel_out   (rsp_chan.channel_out),
      .rsp_sample_out    (rsp_chan.sample_out)
   );

endmodule
